FILE: rtl/jsu_pkg.sv
package jsu_pkg;

    // Decoder phase
    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_STR  = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } t_phase;

    // Result status codes
    typedef enum logic [2:0] {
        ST_UNIT     = 3'd0,
        ST_CLOSED   = 3'd1,
        ST_NO_QUOTE = 3'd2,
        ST_ESC_END  = 3'd3,
        ST_BAD_HEX  = 3'd4,
        ST_BAD_ESC  = 3'd5,
        ST_UNTERM   = 3'd6
    } t_status;

    // Character codes
    localparam logic [15:0] CH_QUOTE = 16'h0022;
    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_SLASH = 16'h002F;
    localparam logic [15:0] CH_B = 16'h0062;
    localparam logic [15:0] CH_F = 16'h0066;
    localparam logic [15:0] CH_N = 16'h006E;
    localparam logic [15:0] CH_R = 16'h0072;
    localparam logic [15:0] CH_T = 16'h0074;
    localparam logic [15:0] CH_U = 16'h0075;
    localparam logic [15:0] CH_BS = 16'h0008;
    localparam logic [15:0] CH_FF = 16'h000C;
    localparam logic [15:0] CH_LF = 16'h000A;
    localparam logic [15:0] CH_CR = 16'h000D;
    localparam logic [15:0] CH_TAB = 16'h0009;

    // Decoder state carried between units
    typedef struct packed {
        t_phase      phase;
        logic [1:0]  hex_cnt;
        logic [11:0] hex_partial;
    } t_dec_state;

    // One step's result
    typedef struct packed {
        logic        valid;
        logic [15:0] unit;
        t_status     status;
    } t_step_res;

endpackage

FILE: rtl/jsu_if.sv
// Input channel: one code unit or an end marker per transfer
interface jsu_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        end_of_input;

    modport source (output valid, output code_unit, output end_of_input, input ready);
    modport sink (input valid, input code_unit, input end_of_input, output ready);
endinterface

// Output channel: one decoded unit or status per transfer
interface jsu_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] decoded_unit;
    logic [2:0]  status;

    modport source (output valid, output decoded_unit, output status, input ready);
    modport sink (input valid, input decoded_unit, input status, output ready);
endinterface

FILE: rtl/jsu_step.sv
// Next-state and result logic for one code unit
module jsu_step (
    input  jsu_pkg::t_dec_state i_state,
    input  logic [15:0]         i_code_unit,
    input  logic                i_end_of_input,
    output jsu_pkg::t_dec_state o_state,
    output jsu_pkg::t_step_res  o_res
);

    // Hex digit decode; bit 4 flags a valid digit
    function automatic logic [4:0] hex_value(input logic [15:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            v = {1'b1, c[3:0]};
        end else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046)) begin
            v = {1'b1, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    logic [4:0] s_hex;

    assign s_hex = hex_value(i_code_unit);

    always_comb begin
        o_state = i_state;
        o_res   = '{valid: 1'b0, unit: 16'd0, status: jsu_pkg::ST_UNIT};

        unique case (i_state.phase)
            jsu_pkg::PH_WAIT: begin
                if (i_end_of_input || i_code_unit != jsu_pkg::CH_QUOTE) begin
                    o_res = '{valid: 1'b1, unit: 16'd0, status: jsu_pkg::ST_NO_QUOTE};
                end else begin
                    o_state.phase = jsu_pkg::PH_STR;
                end
            end

            jsu_pkg::PH_STR: begin
                priority if (i_end_of_input) begin
                    o_state.phase = jsu_pkg::PH_WAIT;
                    o_res = '{valid: 1'b1, unit: 16'd0, status: jsu_pkg::ST_UNTERM};
                end else if (i_code_unit == jsu_pkg::CH_QUOTE) begin
                    o_state.phase = jsu_pkg::PH_WAIT;
                    o_res = '{valid: 1'b1, unit: 16'd0, status: jsu_pkg::ST_CLOSED};
                end else if (i_code_unit == jsu_pkg::CH_BSLASH) begin
                    o_state.phase = jsu_pkg::PH_ESC;
                end else begin
                    o_res = '{valid: 1'b1, unit: i_code_unit, status: jsu_pkg::ST_UNIT};
                end
            end

            jsu_pkg::PH_ESC: begin
                if (i_end_of_input) begin
                    o_state.phase = jsu_pkg::PH_WAIT;
                    o_res = '{valid: 1'b1, unit: 16'd0, status: jsu_pkg::ST_ESC_END};
                end else begin
                    // single-character escapes return to the string body
                    o_state.phase = jsu_pkg::PH_STR;
                    o_res.valid   = 1'b1;
                    unique case (i_code_unit)
                        jsu_pkg::CH_QUOTE:  o_res.unit = jsu_pkg::CH_QUOTE;
                        jsu_pkg::CH_BSLASH: o_res.unit = jsu_pkg::CH_BSLASH;
                        jsu_pkg::CH_SLASH:  o_res.unit = jsu_pkg::CH_SLASH;
                        jsu_pkg::CH_B:      o_res.unit = jsu_pkg::CH_BS;
                        jsu_pkg::CH_F:      o_res.unit = jsu_pkg::CH_FF;
                        jsu_pkg::CH_N:      o_res.unit = jsu_pkg::CH_LF;
                        jsu_pkg::CH_R:      o_res.unit = jsu_pkg::CH_CR;
                        jsu_pkg::CH_T:      o_res.unit = jsu_pkg::CH_TAB;
                        jsu_pkg::CH_U: begin
                            o_state = '{phase: jsu_pkg::PH_HEX, hex_cnt: 2'd0,
                                        hex_partial: 12'd0};
                            o_res.valid = 1'b0;
                        end
                        default: begin
                            o_state.phase = jsu_pkg::PH_WAIT;
                            o_res.status  = jsu_pkg::ST_BAD_ESC;
                        end
                    endcase
                end
            end

            jsu_pkg::PH_HEX: begin
                priority if (i_end_of_input || !s_hex[4]) begin
                    o_state = '{phase: jsu_pkg::PH_WAIT, hex_cnt: 2'd0, hex_partial: 12'd0};
                    o_res = '{valid: 1'b1, unit: 16'd0, status: jsu_pkg::ST_BAD_HEX};
                end else if (i_state.hex_cnt == 2'd3) begin
                    o_state = '{phase: jsu_pkg::PH_STR, hex_cnt: 2'd0, hex_partial: 12'd0};
                    o_res = '{valid: 1'b1, unit: {i_state.hex_partial, s_hex[3:0]},
                              status: jsu_pkg::ST_UNIT};
                end else begin
                    o_state.hex_partial = {i_state.hex_partial[7:0], s_hex[3:0]};
                    o_state.hex_cnt     = i_state.hex_cnt + 2'd1;
                end
            end

            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

FILE: rtl/json_string_unescaper.sv
// JSON string escape decoder. Takes one UTF-16 code unit (or an end-of-input
// marker) per transfer and returns at most one result per item: a decoded unit
// with status 0, or a status code for a closed string or one of five errors,
// after which it waits for a new opening quote. It accepts one item every
// clock cycle; each item passes through the input register and then through
// the decode logic into the result register.
// Throughput drops only while the result register is full and not taken.
module json_string_unescaper (
    input  logic              i_clk,
    input  logic              i_rst_n,
    jsu_in_if.sink            i_in,
    jsu_out_if.source         o_out
);

    logic                r_in_valid;
    logic [15:0]         r_in_unit;
    logic                r_in_eoi;
    jsu_pkg::t_dec_state r_state;
    jsu_pkg::t_dec_state n_state;
    jsu_pkg::t_step_res  s_res;
    logic                r_out_valid;
    logic [15:0]         r_out_unit;
    jsu_pkg::t_status    r_out_status;
    logic                s_advance;

    // Decode step
    jsu_step u_step (
        .i_state        (r_state),
        .i_code_unit    (r_in_unit),
        .i_end_of_input (r_in_eoi),
        .o_state        (n_state),
        .o_res          (s_res)
    );

    // Held item moves on unless its result would hit a full, stalled output
    assign s_advance  = r_in_valid && (!s_res.valid || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || s_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_unit <= i_in.code_unit;
            r_in_eoi  <= i_in.end_of_input;
        end
    end

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: jsu_pkg::PH_WAIT, hex_cnt: 2'd0, hex_partial: 12'd0};
        end else if (s_advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_advance && s_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (s_advance && s_res.valid) begin
            r_out_unit   <= s_res.unit;
            r_out_status <= s_res.status;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.decoded_unit = r_out_unit;
    assign o_out.status       = r_out_status;

    // Hex digit count only runs inside a \u escape
    a_hex_cnt_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.hex_cnt != 2'd0 |-> r_state.phase == jsu_pkg::PH_HEX)
        else $error("hex count set outside hex phase");

    // Partial hex value is clear outside a \u escape
    a_hex_partial_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase != jsu_pkg::PH_HEX |-> r_state.hex_partial == 12'd0)
        else $error("stale hex partial");

    // Non-unit results carry a zero unit
    a_status_unit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != jsu_pkg::ST_UNIT |-> r_out_unit == 16'd0)
        else $error("status result with nonzero unit");

    // A stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !(s_advance && s_res.valid))
        else $error("result overwritten while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_in_valid)
        else $error("pipeline not empty after reset");

endmodule
